// File: hdl/cts_pkg.sv
package cts_pkg;

    localparam int DAC_COUNTS = 64;
    localparam int CODE_W     = 6;
    localparam int MAG_W      = 6;
    localparam int MV_W       = 10;
    localparam int VOLT_W     = 16;

    localparam logic [CODE_W-1:0] START_CODE = 6'h20;
    localparam logic [MAG_W-1:0]  STEP_CAP   = 6'd32;
    localparam int TOP_CODE_I = (DAC_COUNTS - 1 > 63) ? 63 : DAC_COUNTS - 1;
    localparam logic [CODE_W-1:0] TOP_CODE   = CODE_W'(TOP_CODE_I);

    localparam logic [MV_W-1:0] MV_RESET = 10'd420;

    // search state; step kept as sign + magnitude (magnitude 1..32)
    typedef struct packed {
        logic              have_previous;
        logic [CODE_W-1:0] previous_code;
        logic              step_neg;
        logic [MAG_W-1:0]  step_mag;
        logic              previous_comparison;
        logic              widening;
    } cts_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              settled;
        logic [CODE_W-1:0] settled_code;
    } cts_result_t;

endpackage

// File: hdl/comparator_tracking_dac_search.sv
// Each accepted input beat gives its result beat in the next cycle (one result per sample).
// Throughput: 1 sample per cycle while the output is not stalled; the search update and the voltage multiply
// fit between the search state and the output register.
// Reset (rst_n, async low): search restarts, next sample yields code 32,
// millivolts_per_count returns to 420, output register empties.
module comparator_tracking_dac_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cts_pkg::MV_W-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        comparator_high,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cts_pkg::CODE_W-1:0]  dac_code,
    output logic                        converged,
    output logic [cts_pkg::VOLT_W-1:0]  voltage_mv
);
    import cts_pkg::*;

    cts_state_t  state_reg;
    cts_state_t  state_next;
    cts_result_t result;
    logic [MV_W-1:0]   mv_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              conv_reg;
    logic [VOLT_W-1:0] volt_reg;
    logic [VOLT_W-1:0] volt_next;
    logic [CODE_W+MV_W:0] product;
    logic in_fire;

    cts_step u_step (
        .state      (state_reg),
        .comp       (comparator_high),
        .state_next (state_next),
        .result     (result)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign product   = (CODE_W+MV_W+1)'({1'b0, result.settled_code} + (CODE_W+1)'(1))
                       * (CODE_W+MV_W+1)'(mv_reg);
    assign volt_next = result.settled ? product[VOLT_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.have_previous       <= 1'b0;
            state_reg.previous_code       <= '0;
            state_reg.step_neg            <= 1'b0;
            state_reg.step_mag            <= MAG_W'(1);
            state_reg.previous_comparison <= 1'b0;
            state_reg.widening            <= 1'b1;
            mv_reg                        <= MV_RESET;
            out_valid_reg                 <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mv_reg <= cfg_data;
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg <= result.code;
            conv_reg <= result.settled;
            volt_reg <= volt_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dac_code   = code_reg;
    assign converged  = conv_reg;
    assign voltage_mv = volt_reg;

`ifndef NO_ASSERTIONS
    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted sample produced no result beat");

    a_step_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step_mag != '0 && state_reg.step_mag <= STEP_CAP)
        else $error("step magnitude out of range");

    a_volt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !converged |-> voltage_mv == '0)
        else $error("voltage nonzero without convergence");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dac_code <= TOP_CODE)
        else $error("dac code above top of range");

    a_first_code: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !state_reg.have_previous |=> dac_code == START_CODE && !converged)
        else $error("first sample did not start at mid-scale");
`endif

endmodule

// File: hdl/cts_step.sv
module cts_step (
    input  cts_pkg::cts_state_t  state,
    input  logic                 comp,
    output cts_pkg::cts_state_t  state_next,
    output cts_pkg::cts_result_t result
);
    import cts_pkg::*;

    logic             settled;
    logic [CODE_W-1:0] settled_code;
    logic             widen;
    logic [MAG_W:0]   mag_dbl;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] mag_half;
    logic signed [CODE_W+1:0] sum;
    logic [CODE_W-1:0] code;

    always_comb
    begin
        settled      = 1'b0;
        settled_code = '0;
        widen        = state.widening;

        if (state.step_neg && state.step_mag == MAG_W'(1)
            && !state.previous_comparison && comp)
        begin
            settled      = 1'b1;
            settled_code = state.previous_code;
            widen        = 1'b1;
        end
        else if (!state.step_neg && state.step_mag == MAG_W'(1)
                 && state.previous_comparison && !comp)
        begin
            if (state.previous_code != '0)
            begin
                settled      = 1'b1;
                settled_code = state.previous_code - CODE_W'(1);
            end
            widen = 1'b1;
        end
        else if (state.previous_comparison != comp)
        begin
            widen = 1'b0;
        end

        mag_dbl  = {state.step_mag, 1'b0};
        mag_half = state.step_mag >> 1;
        if (widen)
        begin
            if (settled)
                mag = state.step_mag;
            else if (mag_dbl > {1'b0, STEP_CAP})
                mag = STEP_CAP;
            else
                mag = mag_dbl[MAG_W-1:0];
        end
        else
        begin
            mag = (mag_half == '0) ? MAG_W'(1) : mag_half;
        end

        if (comp)
            sum = $signed({2'b00, state.previous_code}) + $signed({2'b00, mag});
        else
            sum = $signed({2'b00, state.previous_code}) - $signed({2'b00, mag});

        if (sum < 0)
            code = '0;
        else if (sum > $signed({2'b00, TOP_CODE}))
            code = TOP_CODE;
        else
            code = sum[CODE_W-1:0];

        if (state.have_previous)
        begin
            state_next.have_previous       = 1'b1;
            state_next.previous_code       = code;
            state_next.step_neg            = !comp;
            state_next.step_mag            = mag;
            state_next.previous_comparison = comp;
            state_next.widening            = widen;
            result.code                    = code;
            result.settled                 = settled;
            result.settled_code            = settled_code;
        end
        else
        begin
            // first sample only seeds the code
            state_next               = state;
            state_next.have_previous = 1'b1;
            state_next.previous_code = START_CODE;
            result.code              = START_CODE;
            result.settled           = 1'b0;
            result.settled_code      = '0;
        end
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int LEVEL_MAX      = 64;   // level above every code: comparator always high

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              conv;
        logic [VOLT_W-1:0] volt;
    } dac_update_t;

    logic               clk;
    logic               rst_n           = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [MV_W-1:0]    cfg_data        = '0;
    logic               in_valid        = 1'b0;
    logic               in_ready;
    logic               comparator_high = 1'b0;
    logic               out_valid;
    logic               out_ready       = 1'b0;
    logic [CODE_W-1:0]  dac_code;
    logic               converged;
    logic [VOLT_W-1:0]  voltage_mv;

    // predictor state and the scale register copy
    cts_state_t         search_st;
    logic [MV_W-1:0]    mv_per_count;
    dac_update_t        dac_updates[$];

    bit                 src_gaps;
    bit                 sink_stalls;
    int                 hold_req;
    int                 errors;
    int                 n_samples;
    int                 n_checked;
    int                 n_settled;
    int                 n_cfg_writes;
    int                 idle_cycles;

    comparator_tracking_dac_search dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .comparator_high (comparator_high),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .dac_code        (dac_code),
        .converged       (converged),
        .voltage_mv      (voltage_mv)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic dac_update_t track_search(input logic cmp);
        dac_update_t r;
        int mag;
        int nxt;
        logic [CODE_W-1:0] hit_code;
        r.code   = START_CODE;
        r.conv   = 1'b0;
        r.volt   = '0;
        hit_code = '0;
        if (search_st.have_previous)
        begin
            if (search_st.step_neg && search_st.step_mag == 1 &&
                !search_st.previous_comparison && cmp)
            begin
                r.conv   = 1'b1;
                hit_code = search_st.previous_code;
                search_st.widening = 1'b1;
            end
            else if (!search_st.step_neg && search_st.step_mag == 1 &&
                     search_st.previous_comparison && !cmp)
            begin
                // bottom of the range cannot settle one below
                if (search_st.previous_code != 0)
                begin
                    r.conv   = 1'b1;
                    hit_code = search_st.previous_code - CODE_W'(1);
                end
                search_st.widening = 1'b1;
            end
            else if (search_st.previous_comparison != cmp)
            begin
                search_st.widening = 1'b0;
            end

            mag = int'(search_st.step_mag);
            if (search_st.widening)
            begin
                if (!r.conv)
                begin
                    mag = mag * 2;
                    if (mag > int'(STEP_CAP))
                        mag = int'(STEP_CAP);
                end
            end
            else
            begin
                mag = mag / 2;
                if (mag < 1)
                    mag = 1;
            end
            search_st.step_neg = !cmp;
            search_st.step_mag = MAG_W'(mag);

            nxt = int'(search_st.previous_code) + (cmp ? mag : -mag);
            if (nxt > TOP_CODE_I)
                nxt = TOP_CODE_I;
            if (nxt < 0)
                nxt = 0;
            r.code = CODE_W'(nxt);
            search_st.previous_comparison = cmp;
        end
        search_st.previous_code = r.code;
        search_st.have_previous = 1'b1;
        if (r.conv)
            r.volt = VOLT_W'((int'(hit_code) + 1) * int'(mv_per_count));
        return r;
    endfunction

    // one comparator beat; valid stays up across back-to-back beats
    task automatic send_sample(input logic cmp);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        comparator_high <= cmp;
        do @(posedge clk); while (!in_ready);
        dac_updates.push_back(track_search(cmp));
        n_samples++;
    endtask

    // comparator against a hidden level, with optional random flips
    task automatic search_level(input int level, input int count, input int flip_pct);
        logic cmp;
        repeat (count)
        begin
            cmp = (level > int'(search_st.previous_code));
            if ($urandom_range(0, 99) < flip_pct)
                cmp = !cmp;
            send_sample(cmp);
        end
    endtask

    // level wanders: held for a random stretch, then moves
    task automatic tracking_run(input int count);
        int left;
        int chunk;
        left = count;
        while (left > 0)
        begin
            chunk = $urandom_range(3, 40);
            if (chunk > left)
                chunk = left;
            search_level($urandom_range(0, LEVEL_MAX), chunk, 8);
            left -= chunk;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (dac_updates.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_scale(input logic [MV_W-1:0] mv);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mv;
        do @(posedge clk); while (!cfg_ready);
        mv_per_count = mv;
        n_cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_first_sample_and_rails();
        // first beat is ignored and lands mid-scale; then step up, and then down to the bottom rail
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_sample(1'b1);
        search_level(LEVEL_MAX, 7, 0);
        search_level(0, 9, 0);
    endtask

    task automatic test_settling();
        // the step narrows toward level 37 from below and ends in unit steps
        search_level(37, 8, 0);
    endtask

    task automatic test_scale_sweep();
        logic [MV_W-1:0] scales[7];
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        scales = '{10'd0, 10'd1023, 10'd1, 10'd1000, MV_W'($urandom), MV_W'($urandom),
                   MV_W'($urandom_range(1, 1000))};
        foreach (scales[i])
        begin
            set_scale(scales[i]);
            tracking_run(110);
        end
    endtask

    task automatic test_noise();
        set_scale(MV_RESET);
        repeat (150)
            send_sample(1'($urandom));
    endtask

    task automatic test_output_holdoff();
        src_gaps = 1'b0;
        hold_req = HOLDOFF_CYCLES;
        tracking_run(40);
    endtask

    task automatic test_back_to_back();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        set_scale(MV_W'($urandom));
        tracking_run(200);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        dac_update_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (dac_updates.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending (code %0d)", $time, dac_code);
            end
            else
            begin
                want = dac_updates.pop_front();
                n_checked++;
                if (want.conv)
                    n_settled++;
                if (dac_code !== want.code)
                begin
                    errors++;
                    $display("%0t: dac_code expected %0d actual %0d",
                             $time, want.code, dac_code);
                end
                if (converged !== want.conv)
                begin
                    errors++;
                    $display("%0t: converged expected %0d actual %0d",
                             $time, want.conv, converged);
                end
                if (voltage_mv !== want.volt)
                begin
                    errors++;
                    $display("%0t: voltage_mv expected %0d actual %0d",
                             $time, want.volt, voltage_mv);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        search_st    = '{have_previous: 1'b0, previous_code: '0, step_neg: 1'b0,
                         step_mag: MAG_W'(1), previous_comparison: 1'b0, widening: 1'b1};
        mv_per_count = MV_RESET;
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        hold_req     = 0;
        errors       = 0;
        n_samples    = 0;
        n_checked    = 0;
        n_settled    = 0;
        n_cfg_writes = 0;
        idle_cycles  = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample_and_rails();
        test_settling();
        test_scale_sweep();
        test_noise();
        test_output_holdoff();
        test_back_to_back();

        settle();
        repeat (4) @(posedge clk);

        $display("Run covered %0d comparator samples and %0d checked results, %0d settled.",
                 n_samples, n_checked, n_settled);
        $display("Scale register written %0d times, including 0 and 1023; one %0d-cycle hold-off.",
                 n_cfg_writes, HOLDOFF_CYCLES);
        if (errors == 0 && dac_updates.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
hdl/cts_pkg.sv
hdl/cts_step.sv
hdl/comparator_tracking_dac_search.sv
tb/sv/testbench.sv
